// ===== design/sc2a_pkg.sv =====
package sc2a_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      CSR_ARROW_UP    = 2'd0,
      CSR_ARROW_DOWN  = 2'd1,
      CSR_ARROW_LEFT  = 2'd2,
      CSR_ARROW_RIGHT = 2'd3
   } csr_index_type;

   // set-1 scan codes
   localparam byte_type SC_CAPS        = 8'h3A;
   localparam byte_type SC_NUM         = 8'h45;
   localparam byte_type SC_SCROLL      = 8'h46;
   localparam byte_type SC_LSHIFT      = 8'h2A;
   localparam byte_type SC_RSHIFT      = 8'h36;
   localparam byte_type SC_LSHIFT_BRK  = 8'hAA;
   localparam byte_type SC_RSHIFT_BRK  = 8'hB6;
   localparam byte_type SC_CTRL        = 8'h1D;
   localparam byte_type SC_CAPS_BRK    = 8'hBA;
   localparam byte_type SC_NUM_BRK     = 8'hC5;
   localparam byte_type SC_SCROLL_BRK  = 8'hC6;
   localparam byte_type SC_ARROW_UP    = 8'h48;
   localparam byte_type SC_ARROW_DOWN  = 8'h50;
   localparam byte_type SC_ARROW_LEFT  = 8'h4B;
   localparam byte_type SC_ARROW_RIGHT = 8'h4D;

   localparam byte_type ARROW_UP_RST    = 8'h80;
   localparam byte_type ARROW_DOWN_RST  = 8'h81;
   localparam byte_type ARROW_LEFT_RST  = 8'h82;
   localparam byte_type ARROW_RIGHT_RST = 8'h83;

   // layout tables, codes 0x00..0x3F
   localparam byte_type PLAIN_LO [64] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'h00, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h00, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h00,
      8'h7B, 8'h7D, 8'h00, 8'h3C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'hB3, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam byte_type SHIFT_LO [64] = '{
      8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
      8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h00, 8'h08, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h00, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h00,
      8'h5B, 8'h5D, 8'h00, 8'h3E, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h00,
      8'h00, 8'h20, 8'h00, 8'hB3, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam byte_type CAPS_LO [64] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'h00, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h00, 8'h2B, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h00,
      8'h7B, 8'h7D, 8'h00, 8'h3C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h00,
      8'h00, 8'h20, 8'h00, 8'hB3, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam byte_type SHIFT_CAPS_LO [64] = '{
      8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
      8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h00, 8'h08, 8'h00,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h00, 8'h2A, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h00,
      8'h5B, 8'h5D, 8'h00, 8'h3E, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h00,
      8'h00, 8'h20, 8'h00, 8'hB3, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // codes 0x40..0x5F, same in every layout
   function automatic byte_type lower_char(input logic [4:0] idx);
      byte_type ch;
      case (idx)
         5'h08:   ch = 8'hC1;
         5'h0A:   ch = 8'h2D;
         5'h0B:   ch = 8'hB4;
         5'h0D:   ch = 8'hC3;
         5'h0E:   ch = 8'h2B;
         5'h10:   ch = 8'hC2;
         5'h12:   ch = 8'hDC;
         5'h13:   ch = 8'hB2;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic byte_type layout_char(input logic shift, input logic caps,
                                            input byte_type sc);
      byte_type ch;
      ch = 8'h00;
      if (sc[7:6] == 2'b00) begin
         case ({shift, caps})
            2'b00:   ch = PLAIN_LO[sc[5:0]];
            2'b01:   ch = CAPS_LO[sc[5:0]];
            2'b10:   ch = SHIFT_LO[sc[5:0]];
            default: ch = SHIFT_CAPS_LO[sc[5:0]];
         endcase
      end else if (sc[7:5] == 3'b010) begin
         ch = lower_char(sc[4:0]);
      end
      return ch;
   endfunction

   function automatic byte_type keypad_char(input byte_type sc);
      byte_type ch;
      case (sc)
         8'h35:   ch = 8'h2F;
         8'h47:   ch = 8'h37;
         8'h48:   ch = 8'h38;
         8'h49:   ch = 8'h39;
         8'h4A:   ch = 8'h2D;
         8'h4B:   ch = 8'h34;
         8'h4C:   ch = 8'h35;
         8'h4D:   ch = 8'h36;
         8'h4E:   ch = 8'h2B;
         8'h4F:   ch = 8'h31;
         8'h50:   ch = 8'h32;
         8'h51:   ch = 8'h33;
         8'h52:   ch = 8'h30;
         8'h53:   ch = 8'h2E;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/scan_code_to_ascii_decoder_top.sv =====
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+---------------------------------------
// req      | in  | req_tvalid/req_tready | tdata[7:0] scan_code
// rsp      | out | rsp_tvalid/rsp_tready | tdata: char_valid, char_code, led_update,
//          |     |                       |        led_bits, zero pad to 16 bits
// csr      | in  | csr_valid/csr_ready   | csr_index[1:0], csr_data[7:0]
//
// One item per cycle sustained while rsp is not stalled; an accepted req reaches
// rsp_tvalid through the input register, then the result register. Lock/shift/control
// flags update when an item moves into the result register. Synchronous active-high
// reset clears the flags and both valid bits and loads the arrow registers with their
// defaults; req_tready and csr_ready are low during reset. A stalled rsp still lets
// one more item into the input register before req_tready drops.
module scan_code_to_ascii_decoder_top
   import sc2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] char_valid, [8:1] char_code, [9] led_update,
                                    // [12:10] led_bits, [15:13] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic     in_valid_ff, in_valid_in;
   byte_type in_code_ff;
   logic     out_valid_ff, out_valid_in;
   logic [12:0] out_data_ff, out_data_in;
   logic     out_ready, advance;

   logic caps_ff, caps_in, num_ff, num_in, scroll_ff, scroll_in;
   logic shift_ff, shift_in, ctrl_ff, ctrl_in;
   byte_type up_ff, down_ff, left_ff, right_ff;

   logic     modifier, led, valid;
   byte_type ch;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !reset && (!in_valid_ff || out_ready);
   assign csr_ready  = !reset;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

   always_comb begin
      caps_in   = caps_ff;
      num_in    = num_ff;
      scroll_in = scroll_ff;
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      modifier  = 1'b1;
      led       = 1'b0;
      valid     = 1'b0;
      ch        = 8'h00;
      case (in_code_ff)
         SC_CAPS: begin
            caps_in = !caps_ff;
            led     = 1'b1;
         end
         SC_NUM: begin
            num_in = !num_ff;
            led    = 1'b1;
         end
         SC_SCROLL:                   scroll_in = !scroll_ff;
         SC_LSHIFT, SC_RSHIFT:         shift_in  = 1'b1;
         SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_in  = 1'b0;
         SC_CTRL:                     ctrl_in   = 1'b1;
         SC_CAPS_BRK, SC_NUM_BRK, SC_SCROLL_BRK: ;
         default:                     modifier  = 1'b0;
      endcase

      if (!modifier) begin
         if (in_code_ff == SC_ARROW_UP) begin
            ch    = up_ff;
            valid = 1'b1;
         end else if (in_code_ff == SC_ARROW_DOWN) begin
            ch    = down_ff;
            valid = 1'b1;
         end else if (in_code_ff == SC_ARROW_LEFT) begin
            ch    = left_ff;
            valid = 1'b1;
         end else if (in_code_ff == SC_ARROW_RIGHT) begin
            ch    = right_ff;
            valid = 1'b1;
         end else if (ctrl_ff && num_ff &&
                      (in_code_ff inside {8'h35, [8'h47:8'h49], [8'h4B:8'h53]})) begin
            ch    = keypad_char(in_code_ff);
            valid = ch != 8'h00;
         end else if (layout_char(1'b0, 1'b0, in_code_ff) != 8'h00) begin
            // plain table gates all layouts
            ch    = layout_char(shift_ff, caps_ff, in_code_ff);
            valid = ch != 8'h00;
         end
      end
      if (!valid) begin
         ch = 8'h00;
      end

      out_data_in = {caps_in, num_in, scroll_in, led, ch, valid};
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         caps_ff      <= 1'b0;
         num_ff       <= 1'b0;
         scroll_ff    <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         up_ff        <= ARROW_UP_RST;
         down_ff      <= ARROW_DOWN_RST;
         left_ff      <= ARROW_LEFT_RST;
         right_ff     <= ARROW_RIGHT_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            caps_ff   <= caps_in;
            num_ff    <= num_in;
            scroll_ff <= scroll_in;
            shift_ff  <= shift_in;
            ctrl_ff   <= ctrl_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ARROW_UP:    up_ff    <= csr_data;
               CSR_ARROW_DOWN:  down_ff  <= csr_data;
               CSR_ARROW_LEFT:  left_ff  <= csr_data;
               CSR_ARROW_RIGHT: right_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_code_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_no_char_zero_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[0] || out_data_ff[8:1] == 8'h00))
      else $error("char_code nonzero without char_valid");

   a_ctrl_sticky: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff |=> ctrl_ff)
      else $error("control latch cleared");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff))
      else $error("req stalled with room in the pipe");

   a_scroll_toggle: assert property (@(posedge clock) disable iff (reset)
      (advance && in_code_ff == SC_SCROLL) |=> (scroll_ff != $past(scroll_ff)))
      else $error("scroll lock did not toggle");

   a_led_flags: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_data_ff[12:10] == {caps_ff, num_ff, scroll_ff}))
      else $error("led_bits differ from lock flags");

endmodule
